// File: sv/rsg_pkg.sv
// shared types, codes and reset values of the restart schedule generator
package rsg_pkg;

  // schedule mode codes, mode value three behaves as geometric
  localparam logic [1:0] MODE_GEOM  = 2'd0;
  localparam logic [1:0] MODE_ARITH = 2'd1;
  localparam logic [1:0] MODE_LUBY  = 2'd2;

  // item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_NEXT  = 2'd1;
  localparam logic [1:0] KIND_ADV   = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_BASE   = 2'd1;
  localparam logic [1:0] REG_GROWTH = 2'd2;
  localparam logic [1:0] REG_RUNLIM = 2'd3;

  localparam logic [1:0]  RST_MODE   = MODE_LUBY;
  localparam logic [31:0] RST_BASE   = 32'd100;
  localparam logic [23:0] RST_GROWTH = 24'd98304;
  localparam logic [31:0] RST_RUNLIM = 32'd0;

  localparam logic [23:0] ONE_Q16 = 24'h010000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD,
    S_ADV,
    S_LIMIT,
    S_LUBY,
    S_GTEST,
    S_GWR,
    S_GSHIFT,
    S_GWS,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic upd_start;
    logic upd_next;
    logic adv_step;
    logic seq_set;
    logic arith_mul;
    logic luby_init;
    logic luby_step;
    logic luby_mul;
    logic geo_init;
    logic mul_start;
    logic mul_sel_s;
    logic geo_wr_r;
    logic geo_wr_s;
    logic geo_shift;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] mode;
    logic       base_zero;
    logic       adv_cont;
    logic       luby_done;
    logic       e_zero;
    logic       e_bit0;
    logic       e_last;
    logic       mul_done;
  } sts_t;

endpackage

// File: sv/rsg_qmul.sv
// multi-cycle q64.16 multiplier with saturation, one 32x32 partial product a cycle
module rsg_qmul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [79:0] a,
  input  logic        a_sat,
  input  logic [79:0] b,
  input  logic        b_sat,
  output logic        busy,
  output logic        done,
  output logic [79:0] p,
  output logic        p_sat
);
  import rsg_pkg::*;

  logic [79:0]  a_r, b_r;
  logic         sat_r, ovf_r, ovf_nxt;
  logic [95:0]  acc_r, acc_nxt;
  logic [63:0]  pp_r;
  logic [2:0]   psh_r;
  logic [1:0]   i_r, j_r;
  logic [3:0]   cnt_r;
  logic         busy_r, done_r;
  logic [128:0] ppx, sum;

  function automatic logic [31:0] limb(input logic [79:0] v, input logic [1:0] k);
    logic [31:0] res;
    case (k)
      2'd0:    res = v[31:0];
      2'd1:    res = v[63:32];
      2'd2:    res = {16'd0, v[79:64]};
      default: res = 32'd0;
    endcase
    return res;
  endfunction

  // place partial product at its column, anything at or above 2^96 overflows
  always_comb begin
    ppx = 129'd0;
    ovf_nxt = ovf_r;
    case (psh_r)
      3'd0:    ppx = {65'd0, pp_r};
      3'd1:    ppx = {33'd0, pp_r, 32'd0};
      3'd2:    ppx = {1'b0, pp_r, 64'd0};
      default: ovf_nxt = ovf_r | (pp_r != 64'd0);
    endcase
    sum = {33'd0, acc_r} + ppx;
    ovf_nxt = ovf_nxt | (sum[128:96] != 33'd0);
    acc_nxt = sum[95:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd0;
        i_r    <= 2'd0;
        j_r    <= 2'd0;
        a_r    <= a;
        b_r    <= b;
        sat_r  <= a_sat | b_sat;
        acc_r  <= 96'd0;
        ovf_r  <= 1'b0;
      end else if (busy_r) begin
        if (cnt_r <= 4'd8) begin
          pp_r  <= limb(a_r, i_r) * limb(b_r, j_r);
          psh_r <= {1'b0, i_r} + {1'b0, j_r};
          if (j_r == 2'd2) begin
            j_r <= 2'd0;
            i_r <= i_r + 2'd1;
          end else begin
            j_r <= j_r + 2'd1;
          end
        end
        if (cnt_r >= 4'd1) begin
          acc_r <= acc_nxt;
          ovf_r <= ovf_nxt;
        end
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd9) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy  = busy_r;
  assign done  = done_r;
  assign p     = acc_r[95:16];
  assign p_sat = sat_r | ovf_r;

endmodule

// File: sv/rsg_dp.sv
// datapath: configuration, sequence state, luby, arithmetic and geometric evaluation
module rsg_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic [1:0]    in_kind,
  input  logic [31:0]   in_target_index,
  input  rsg_pkg::cmd_t cmd,
  output rsg_pkg::sts_t sts,
  output logic [63:0]   out_limit_value
);
  import rsg_pkg::*;

  logic [1:0]  mode_r;
  logic [31:0] base_r, runlim_r;
  logic [23:0] growth_r;
  logic [1:0]  kind_r;
  logic [31:0] n_r, seq_r, rl_r;
  logic [32:0] li_r;
  logic [63:0] prod_r, out_r;
  logic [79:0] r_r, s_r;
  logic        rsat_r, ssat_r;
  logic [31:0] e_r;

  logic        luby;
  logic [31:0] rm1, start_len, s1, grow, next_len;
  logic [32:0] sm_rl, v33, sm_li, hb, li_p1;
  logic [31:0] op_a, op_b;
  logic [23:0] g_eff;
  logic [63:0] x_geo, res;
  logic        mul_busy, mul_done, p_sat;
  logic [79:0] p;

  function automatic logic [32:0] smear(input logic [32:0] v);
    logic [32:0] t;
    t = v;
    t = t | (t >> 1);
    t = t | (t >> 2);
    t = t | (t >> 4);
    t = t | (t >> 8);
    t = t | (t >> 16);
    t = t | (t >> 32);
    return t;
  endfunction

  assign luby = (mode_r == MODE_LUBY);

  // luby start length: (2^k - 1) * 2, at least 2, saturated
  assign rm1   = runlim_r - 32'd1;
  assign sm_rl = smear({1'b0, rm1});
  assign v33   = {sm_rl[31:0], 1'b0};
  always_comb begin
    if (!luby || runlim_r == 32'd0) start_len = runlim_r;
    else if (v33[32])               start_len = 32'hFFFF_FFFF;
    else if (v33 < 33'd2)           start_len = 32'd2;
    else                            start_len = v33[31:0];
  end

  assign grow = luby ? ((rl_r + 32'd1) << 1) : (rl_r + 32'd1);
  assign s1   = seq_r + 32'd1;
  always_comb begin
    next_len = rl_r + {31'd0, s1 != 32'd0};
    if (luby) next_len = next_len << 1;
  end

  // luby reduction: clear top bit and add one
  assign sm_li = smear(li_r);
  assign hb    = li_r & ~(sm_li >> 1);
  assign li_p1 = li_r + 33'd1;

  assign op_a  = cmd.luby_mul ? base_r : {8'd0, growth_r};
  assign op_b  = cmd.luby_mul ? li_p1[32:1] : seq_r;
  assign g_eff = (growth_r < ONE_Q16) ? ONE_Q16 : growth_r;

  rsg_qmul u_qmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (cmd.mul_sel_s ? s_r : r_r),
    .a_sat (cmd.mul_sel_s ? ssat_r : rsat_r),
    .b     (s_r),
    .b_sat (ssat_r),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (p),
    .p_sat (p_sat)
  );

  assign x_geo = r_r[79:16];
  always_comb begin
    if (base_r == 32'd0)          res = 64'hFFFF_FFFF_FFFF_FFFF;
    else if (mode_r == MODE_ARITH) res = {32'd0, base_r} + {24'd0, prod_r[55:16]};
    else if (luby)                 res = prod_r;
    else if (rsat_r)               res = 64'hFFFF_FFFF_FFFF_FFFF;
    else                           res = x_geo + {63'd0, x_geo == 64'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= RST_MODE;
      base_r   <= RST_BASE;
      growth_r <= RST_GROWTH;
      runlim_r <= RST_RUNLIM;
      seq_r    <= 32'd0;
      rl_r     <= 32'd0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MODE:   mode_r   <= cfg_data[1:0];
          REG_BASE:   base_r   <= cfg_data;
          REG_GROWTH: growth_r <= cfg_data[23:0];
          REG_RUNLIM: runlim_r <= cfg_data;
          default:    ;
        endcase
      end
      if (cmd.upd_start) begin
        seq_r <= 32'd0;
        rl_r  <= start_len;
      end
      if (cmd.upd_next) begin
        if (s1 == rl_r) begin
          seq_r <= 32'd0;
          rl_r  <= next_len;
        end else begin
          seq_r <= s1;
        end
      end
      if (cmd.adv_step) rl_r <= grow;
      if (cmd.seq_set) seq_r <= n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      n_r    <= in_target_index;
    end
    if (cmd.adv_step) n_r <= n_r - rl_r;
    if (cmd.luby_init) li_r <= {1'b0, seq_r} + 33'd1;
    if (cmd.luby_step) li_r <= (li_r ^ hb) + 33'd1;
    if (cmd.arith_mul || cmd.luby_mul) prod_r <= op_a * op_b;
    if (cmd.geo_init) begin
      r_r    <= {32'd0, base_r, 16'd0};
      rsat_r <= 1'b0;
      s_r    <= {56'd0, g_eff};
      ssat_r <= 1'b0;
      e_r    <= seq_r;
    end
    if (cmd.geo_wr_r) begin
      r_r    <= p;
      rsat_r <= p_sat;
    end
    if (cmd.geo_wr_s) begin
      s_r    <= p;
      ssat_r <= p_sat;
    end
    if (cmd.geo_shift) e_r <= e_r >> 1;
    if (cmd.out_load) out_r <= res;
  end

  assign sts.kind      = kind_r;
  assign sts.mode      = mode_r;
  assign sts.base_zero = (base_r == 32'd0);
  assign sts.adv_cont  = (rl_r != 32'd0) && (n_r >= rl_r);
  assign sts.luby_done = ((li_r & li_p1) == 33'd0);
  assign sts.e_zero    = (e_r == 32'd0);
  assign sts.e_bit0    = e_r[0];
  assign sts.e_last    = (e_r[31:1] == 31'd0);
  assign sts.mul_done  = mul_done;

  assign out_limit_value = out_r;

  a_adv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.seq_set |=> (rl_r == 32'd0 || seq_r < rl_r))
    else $error("index left beyond run length after advance");

  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_luby_nz: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.luby_step |=> li_r != 33'd0)
    else $error("luby reduction reached zero");

  a_luby_len: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd_start && luby && runlim_r != 32'd0) |=> rl_r >= 32'd2)
    else $error("luby run length below two");

endmodule

// File: sv/rsg_ctrl.sv
// controller state machine sequencing the datapath for one item
module rsg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  rsg_pkg::sts_t sts,
  output rsg_pkg::cmd_t cmd
);
  import rsg_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_UPD;
      S_UPD:    state_nxt = (sts.kind == KIND_ADV) ? S_ADV : S_LIMIT;
      S_ADV:    if (!sts.adv_cont) state_nxt = S_LIMIT;
      S_LIMIT: begin
        if (sts.base_zero || sts.mode == MODE_ARITH) state_nxt = S_FIN;
        else if (sts.mode == MODE_LUBY)              state_nxt = S_LUBY;
        else                                         state_nxt = S_GTEST;
      end
      S_LUBY:   if (sts.luby_done) state_nxt = S_FIN;
      S_GTEST: begin
        if (sts.e_zero)      state_nxt = S_FIN;
        else if (sts.e_bit0) state_nxt = S_GWR;
        else                 state_nxt = S_GSHIFT;
      end
      S_GWR:    if (sts.mul_done) state_nxt = S_GSHIFT;
      S_GSHIFT: state_nxt = sts.e_last ? S_GTEST : S_GWS;
      S_GWS:    if (sts.mul_done) state_nxt = S_GTEST;
      S_FIN:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: cmd.load = in_valid;
      S_UPD: begin
        cmd.upd_start = (sts.kind == KIND_START);
        cmd.upd_next  = (sts.kind == KIND_NEXT);
      end
      S_ADV: begin
        cmd.adv_step = sts.adv_cont;
        cmd.seq_set  = !sts.adv_cont;
      end
      S_LIMIT: begin
        if (!sts.base_zero) begin
          cmd.arith_mul = (sts.mode == MODE_ARITH);
          cmd.luby_init = (sts.mode == MODE_LUBY);
          cmd.geo_init  = (sts.mode != MODE_ARITH) && (sts.mode != MODE_LUBY);
        end
      end
      S_LUBY: begin
        cmd.luby_mul  = sts.luby_done;
        cmd.luby_step = !sts.luby_done;
      end
      S_GTEST:  cmd.mul_start = !sts.e_zero && sts.e_bit0;
      S_GWR:    cmd.geo_wr_r = sts.mul_done;
      S_GSHIFT: begin
        cmd.geo_shift = 1'b1;
        cmd.mul_start = !sts.e_last;
        cmd.mul_sel_s = 1'b1;
      end
      S_GWS:    cmd.geo_wr_s = sts.mul_done;
      S_FIN:    cmd.out_load = out_free;
      default:  cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: sv/restart_schedule_generator.sv
// top level of the restart schedule generator
// Each transfer on the input channel (start, next, advance-to or read) yields exactly one
// restart limit on the output channel. Items are handled one at a time: the input stalls from
// the cycle after a transfer until the result has been placed in the output register, and a
// new item is taken while that result still waits. Start, next and read in arithmetic mode
// need no evaluation loop; luby adds one step per reduction of the index; geometric runs up
// to two q64.16 multiplies per index bit on the shared 32x32 unit, besides the test and shift
// states per index bit; advance-to adds one step per run length skipped. A zero base gives the
// all-ones limit at once. Configuration is written through the plain write port and must only
// change while the block is idle.
module restart_schedule_generator (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_target_index,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_limit_value,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import rsg_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: one item from transfer to result
  rsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: registers, index update and limit evaluation
  rsg_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_kind         (in_kind),
    .in_target_index (in_target_index),
    .cmd             (cmd),
    .sts             (sts),
    .out_limit_value (out_limit_value)
  );

endmodule

// File: bench/restart_schedule_generator_tb.sv
// self-checking testbench of the restart schedule generator
`timescale 1ns / 1ps

module restart_schedule_generator_tb;
  import rsg_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int RANDOM_ITEMS   = 1150;

  // expected-limit store plus a private copy of the schedule state
  class limit_scoreboard;
    logic [1:0]  mode;
    logic [31:0] base;
    logic [23:0] growth;
    logic [31:0] runlim;
    logic [31:0] seq_idx;
    logic [31:0] run_len;
    logic [63:0] limits_due[$];
    int          n_in;
    int          n_out;

    function void clear();
      mode = RST_MODE; base = RST_BASE; growth = RST_GROWTH; runlim = RST_RUNLIM;
      seq_idx = '0; run_len = '0; limits_due.delete(); n_in = 0; n_out = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_MODE:   mode = data[1:0];
        REG_BASE:   base = data;
        REG_GROWTH: growth = data[23:0];
        default:    runlim = data;
      endcase
    endfunction

    // q64.16 product, truncated, saturating at 2^80 units
    function void qmul(input logic [79:0] x, input bit xs, input logic [79:0] y,
                       input bit ys, output logic [79:0] z, output bit zs);
      logic [159:0] p;
      p = {80'd0, x} * {80'd0, y};
      p = p >> 16;
      zs = xs || ys || (p[159:80] != 0);
      z = p[79:0];
    endfunction

    function logic [63:0] luby_of(logic [31:0] idx);
      logic [63:0] i;
      int k;
      i = {32'd0, idx} + 64'd1;
      while ((i & (i + 64'd1)) != 0) begin
        k = 0;
        while (k < 63 && (i >> (k + 1)) != 0) k++;
        i = i - ((64'd1 << k) - 64'd1);
      end
      return (i + 64'd1) >> 1;
    endfunction

    function logic [63:0] limit_now();
      logic [79:0] r, s;
      bit rs, ss;
      logic [31:0] e;
      logic [63:0] x;
      if (base == 0) return '1;
      if (mode == MODE_ARITH)
        return {32'd0, base} + (({40'd0, growth} * {32'd0, seq_idx}) >> 16);
      if (mode == MODE_LUBY) return luby_of(seq_idx) * {32'd0, base};
      // geometric, also for mode value three
      r = {32'd0, base, 16'd0}; rs = 0;
      s = (growth < ONE_Q16) ? 80'h10000 : {56'd0, growth}; ss = 0;
      e = seq_idx;
      while (e != 0) begin
        if (e[0]) qmul(r, rs, s, ss, r, rs);
        e = e >> 1;
        if (e != 0) qmul(s, ss, s, ss, s, ss);
      end
      if (rs) return '1;
      x = r[79:16];
      return (x == 0) ? 64'd1 : x;
    endfunction

    function logic [31:0] grown(logic [31:0] len);
      return (mode == MODE_LUBY) ? ((len + 32'd1) << 1) : len + 32'd1;
    endfunction

    function void note_input(logic [1:0] kind, logic [31:0] tgt);
      int k;
      logic [63:0] v;
      logic [31:0] n;
      n_in++;
      case (kind)
        KIND_START: begin
          seq_idx = '0;
          run_len = runlim;
          if (mode == MODE_LUBY && runlim != 0) begin
            k = 0;
            while ((64'd1 << k) < {32'd0, runlim}) k++;
            v = ((64'd1 << k) - 64'd1) << 1;
            if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
            if (v < 64'd2) v = 64'd2;
            run_len = v[31:0];
          end
        end
        KIND_NEXT: begin
          seq_idx = seq_idx + 32'd1;
          if (seq_idx == run_len) begin
            n = run_len + ((seq_idx != 0) ? 32'd1 : 32'd0);
            if (mode == MODE_LUBY) n = n << 1;
            run_len = n;
            seq_idx = '0;
          end
        end
        KIND_ADV: begin
          n = tgt;
          while (run_len != 0 && n >= run_len) begin
            n = n - run_len;
            run_len = grown(run_len);
          end
          seq_idx = n;
        end
        default: ;
      endcase
      limits_due.insert(limits_due.size(), limit_now());
    endfunction

    function bit check_result(logic [63:0] got, output logic [63:0] want, output bit none);
      n_out++;
      none = (limits_due.size() == 0);
      if (none) begin
        want = '0;
        return 0;
      end
      want = limits_due.pop_front();
      return got === want;
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_kind = KIND_READ;
  logic [31:0] in_target_index = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [63:0] out_limit_value;
  logic        cfg_wr_en = 0;
  logic [1:0]  cfg_index = REG_MODE;
  logic [31:0] cfg_data = '0;

  limit_scoreboard sb;
  int  mismatches = 0;
  bit  no_gaps = 0;   // stretches with no idling on either side
  int  stall_left = 0;
  int  quiet = 0;

  always #10 clk = ~clk;

  restart_schedule_generator dut (.*);

  task automatic report(string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  // one transfer on the input channel, valid held over when no gap follows
  task automatic send_item(logic [1:0] kind, logic [31:0] tgt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_target_index <= tgt;
    do @(posedge clk); while (in_stall);
    sb.note_input(kind, tgt);
  endtask

  // let every expected limit come out, then a short settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.limits_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic setup(logic [1:0] m, logic [31:0] b, logic [23:0] g, logic [31:0] rl);
    drain();
    write_reg(REG_MODE, {30'd0, m});
    write_reg(REG_BASE, b);
    write_reg(REG_GROWTH, {8'd0, g});
    write_reg(REG_RUNLIM, rl);
  endtask

  // keep advance-to affordable: the block steps once per run length skipped
  function automatic logic [31:0] pick_target();
    if (sb.run_len == 0 || sb.mode == MODE_LUBY || sb.run_len > 32'h0010_0000)
      return $urandom();
    if ($urandom_range(3) == 0) return $urandom_range(sb.run_len * 3);
    return $urandom_range(20000);
  endfunction

  task automatic random_item();
    int r;
    logic [1:0] kind;
    r = $urandom_range(99);
    if (r < 8) kind = KIND_START;
    else if (r < 60) kind = KIND_NEXT;
    else if (r < 80) kind = KIND_ADV;
    else kind = KIND_READ;
    send_item(kind, (kind == KIND_ADV) ? pick_target() : $urandom());
  endtask

  // result side: check each transfer, then choose the next stall
  always @(posedge clk) begin
    logic [63:0] want;
    bit none;
    if (rst_n && out_valid && !out_stall) begin
      if (!sb.check_result(out_limit_value, want, none)) begin
        if (none) report($sformatf("limit %h with nothing expected", out_limit_value));
        else report($sformatf("limit %h, expected %h", out_limit_value, want));
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", quiet);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] b, rl;
    logic [23:0] g;
    int done;
    sb = new();
    sb.clear();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults, luby with unlimited run
    send_item(KIND_READ, 32'hFFFF_FFFF);
    send_item(KIND_NEXT, 32'd0);
    send_item(KIND_NEXT, 32'd0);
    send_item(KIND_ADV, 32'hFFFF_FFFF);
    send_item(KIND_ADV, 32'hFFFF_FFFE);
    send_item(KIND_START, 32'd0);
    // luby run limit rounding, smallest and largest
    setup(MODE_LUBY, 32'd1, 24'd0, 32'd1);
    send_item(KIND_START, 32'd0);
    send_item(KIND_NEXT, 32'd0);
    send_item(KIND_NEXT, 32'd0);
    send_item(KIND_ADV, 32'd100);
    setup(MODE_LUBY, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_START, 32'd0);
    send_item(KIND_ADV, 32'hFFFF_FFFE);
    // zero base gives all ones
    setup(MODE_ARITH, 32'd0, 24'hFF_FFFF, 32'd3);
    send_item(KIND_START, 32'd0);
    send_item(KIND_NEXT, 32'd0);
    // arithmetic extremes, run wrap by next
    setup(MODE_ARITH, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'd2);
    send_item(KIND_START, 32'd0);
    send_item(KIND_NEXT, 32'd0);
    send_item(KIND_NEXT, 32'd0);
    send_item(KIND_ADV, 32'd7);
    // geometric with growth below one, then saturation, then mode three
    setup(MODE_GEOM, 32'd5, 24'd1, 32'd0);
    send_item(KIND_ADV, 32'hFFFF_FFFF);
    setup(MODE_GEOM, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'd0);
    send_item(KIND_ADV, 32'd3);
    send_item(KIND_ADV, 32'h8000_0000);
    setup(2'd3, 32'd1, 24'h01_8000, 32'd0);
    send_item(KIND_ADV, 32'd40);
    send_item(KIND_READ, 32'd0);

    // random phases, each with its own setting
    done = 0;
    while (done < RANDOM_ITEMS) begin
      case ($urandom_range(3))
        0: b = 32'd0;
        1: b = $urandom_range(200, 1);
        2: b = 32'hFFFF_FFFF;
        default: b = $urandom();
      endcase
      if ($urandom_range(9) == 0) b = 32'd0;
      else if (b == 0) b = $urandom_range(50, 1);
      case ($urandom_range(3))
        0: g = 24'($urandom_range(24'hFFFF));
        1: g = ONE_Q16;
        2: g = 24'($urandom_range(24'h02_0000, 24'h01_0001));
        default: g = 24'($urandom());
      endcase
      case ($urandom_range(3))
        0: rl = 32'd0;
        1: rl = $urandom_range(20, 1);
        2: rl = $urandom_range(2000, 21);
        default: rl = $urandom();
      endcase
      no_gaps = ($urandom_range(4) == 0);
      setup(2'($urandom_range(3)), b, g, rl);
      send_item(KIND_START, $urandom());
      repeat ($urandom_range(80, 30)) begin
        random_item();
        done++;
      end
    end
    no_gaps = 0;

    drain();
    repeat (50) @(posedge clk);
    while (sb.limits_due.size() != 0) begin
      report($sformatf("limit %h never arrived", sb.limits_due.pop_front()));
    end
    $display("covered %0d input transfers and %0d limit checks", sb.n_in, sb.n_out);
    $display("all schedule modes, register extremes, run wraps and advance-to jumps");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
